### src/wdfb_pkg.sv
// Shared types and constants for the wireless-LAN data frame builder.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package wdfb_pkg;

   localparam int unsigned HdrLen = 24;
   localparam int unsigned FcsLen = 4;
   localparam logic [15:0] HDR_FC_WORD = 16'h0008;
   localparam logic [15:0] DURATION = 16'h002e;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic [1:0] REG_DEST = 2'd0;
   localparam logic [1:0] REG_SOURCE = 2'd1;
   localparam logic [1:0] REG_BSS = 2'd2;

   // One classified work item handed from the front part to the back part.
   typedef struct packed {
      logic [7:0] data;
      logic       hdr;
      logic       has_data;
      logic       fcs;
   } cmd_type;

   typedef struct packed {
      logic [47:0] dest;
      logic [47:0] source;
      logic [47:0] bss;
   } addr_cfg_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### src/wdfb_front.sv
// Front part of the frame builder: accepts input beats and classifies them.
// Depends on wdfb_pkg; feeds wdfb_queue.
`default_nettype none
module wdfb_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   input  wire [7:0]            in_data,
   input  wire                  in_first,
   input  wire                  in_last,
   input  wire                  in_empty,
   input  wire                  q_full,
   output logic                 in_ready,
   output logic                 push,
   output wdfb_pkg::cmd_type    push_cmd
);
   import wdfb_pkg::*;

   logic inside_ff;
   logic inside_in;

   assign in_ready = !q_full;
   assign push = in_valid && !q_full;

   always_comb begin
      push_cmd.data = in_data;
      inside_in = inside_ff;
      if (in_empty) begin
         push_cmd.hdr = 1'b1;
         push_cmd.has_data = 1'b0;
         push_cmd.fcs = 1'b1;
      end else begin
         push_cmd.hdr = in_first || !inside_ff;
         push_cmd.has_data = 1'b1;
         push_cmd.fcs = in_last;
      end
      if (push) begin
         inside_in = !in_empty && !in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
      end else begin
         inside_ff <= inside_in;
      end
   end

endmodule
`default_nettype wire

### src/wdfb_queue.sv
// Short command queue between the front and back parts of the frame builder.
// Depends on wdfb_pkg for the command type.
`default_nettype none
module wdfb_queue #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wdfb_pkg::cmd_type    push_cmd,
   input  wire                  pop,
   output logic                 full,
   output logic                 not_empty,
   output wdfb_pkg::cmd_type    head
);
   import wdfb_pkg::*;

   localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

   cmd_type       entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == CntW'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head = entry_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

### src/wdfb_back.sv
// Back part of the frame builder: sequences header, payload and FCS beats,
// keeps the CRC and sequence counter, and owns the output register. Uses wdfb_pkg.
`default_nettype none
module wdfb_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wdfb_pkg::addr_cfg_type  addr_cfg,
   input  wire                     q_not_empty,
   input  wdfb_pkg::cmd_type       q_head,
   output logic                    q_pop,
   output logic                    out_valid,
   output logic [7:0]              out_byte,
   output logic                    out_end,
   input  wire                     out_ready
);
   import wdfb_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_HDR  = 4'b0010,
      ST_DATA = 4'b0100,
      ST_FCS  = 4'b1000
   } phase_type;

   phase_type   state_ff, state_in, cur_phase;
   cmd_type     cmd_ff, cmd_in, cur_cmd;
   logic [4:0]  idx_ff, idx_in, cur_idx;
   logic [31:0] crc_ff, crc_in, crc_base;
   logic [11:0] seq_ff, seq_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        end_ff, end_in;
   logic        step;
   logic [47:0] hdr_addr;
   logic [2:0]  addr_off;
   logic [31:0] fcs;

   assign out_valid = valid_ff;
   assign out_byte = byte_ff;
   assign out_end = end_ff;

   assign step = (!valid_ff || out_ready) && ((state_ff != ST_IDLE) || q_not_empty);
   assign q_pop = step && (state_ff == ST_IDLE);
   assign fcs = ~crc_ff;

   always_comb begin
      if (state_ff == ST_IDLE) begin
         cur_cmd = q_head;
         cur_idx = '0;
         if (q_head.hdr) begin
            cur_phase = ST_HDR;
         end else if (q_head.has_data) begin
            cur_phase = ST_DATA;
         end else begin
            cur_phase = ST_FCS;
         end
      end else begin
         cur_cmd = cmd_ff;
         cur_idx = idx_ff;
         cur_phase = state_ff;
      end
   end

   always_comb begin
      if (cur_idx < 5'd10) begin
         hdr_addr = addr_cfg.dest;
         addr_off = 3'(cur_idx - 5'd4);
      end else if (cur_idx < 5'd16) begin
         hdr_addr = addr_cfg.source;
         addr_off = 3'(cur_idx - 5'd10);
      end else begin
         hdr_addr = addr_cfg.bss;
         addr_off = 3'(cur_idx - 5'd16);
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      idx_in = idx_ff;
      crc_in = crc_ff;
      seq_in = seq_ff;
      byte_in = byte_ff;
      end_in = end_ff;
      valid_in = valid_ff && !out_ready;
      crc_base = (cur_phase == ST_HDR && cur_idx == '0) ? CRC_INIT : crc_ff;
      if (step) begin
         valid_in = 1'b1;
         end_in = 1'b0;
         cmd_in = cur_cmd;
         case (cur_phase)
            ST_HDR: begin
               if (cur_idx == 5'd0) begin
                  byte_in = HDR_FC_WORD[7:0];
               end else if (cur_idx == 5'd1) begin
                  byte_in = HDR_FC_WORD[15:8];
               end else if (cur_idx == 5'd2) begin
                  byte_in = DURATION[7:0];
               end else if (cur_idx == 5'd3) begin
                  byte_in = DURATION[15:8];
               end else if (cur_idx == 5'd22) begin
                  byte_in = {seq_ff[3:0], 4'd0};
               end else if (cur_idx == 5'd23) begin
                  byte_in = seq_ff[11:4];
               end else begin
                  byte_in = 8'(hdr_addr >> {addr_off, 3'b000});
               end
               crc_in = crc_byte(crc_base, byte_in);
               if (cur_idx == 5'(HdrLen - 1)) begin
                  seq_in = seq_ff + 1'b1;
                  idx_in = '0;
                  if (cur_cmd.has_data) begin
                     state_in = ST_DATA;
                  end else begin
                     state_in = ST_FCS;
                  end
               end else begin
                  idx_in = cur_idx + 1'b1;
                  state_in = ST_HDR;
               end
            end
            ST_DATA: begin
               byte_in = cur_cmd.data;
               crc_in = crc_byte(crc_base, byte_in);
               idx_in = '0;
               state_in = cur_cmd.fcs ? ST_FCS : ST_IDLE;
            end
            ST_FCS: begin
               byte_in = 8'(fcs >> {cur_idx[1:0], 3'b000});
               if (cur_idx == 5'(FcsLen - 1)) begin
                  end_in = 1'b1;
                  crc_in = CRC_INIT;
                  idx_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = cur_idx + 1'b1;
                  state_in = ST_FCS;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      byte_ff <= byte_in;
      end_ff <= end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         crc_ff <= CRC_INIT;
         seq_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         crc_ff <= crc_in;
         seq_ff <= seq_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

### src/wlan_data_frame_builder_unit.sv
// Wireless-LAN data frame builder: adds header and CRC-32 FCS around payload bytes.
// Top level; uses wdfb_pkg, wdfb_front, wdfb_queue and wdfb_back.
//
// Payload beats enter on the req_ stream: tdata is the byte, tlast marks the
// last payload byte, tuser bit 0 marks the first byte and bit 1 requests an
// empty-body frame. Frame beats leave on the rsp_ stream one byte per beat,
// tlast set on the final FCS byte. The three 48-bit addresses are written
// through the csr_ port at byte addresses 0, 8 and 16.
// An accepted beat is written into the command queue, and the back part moves it
// into the output register when it is free. Payload bytes flow at one per cycle
// while rsp_tready is high; a new frame adds its 24 header bytes and the end of
// a frame its 4 FCS bytes, as the back part emits one byte per cycle. The input
// keeps accepting into a QUEUE_DEPTH-entry command queue while the output is busy
// or stalled. When rsp_tready is low the output beat holds and the back part
// waits; the input stalls once the queue fills. Reset clears the queue, the
// sequence counter, the CRC and the addresses.
`default_nettype none
module wlan_data_frame_builder_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] data_byte
   input  wire         req_tlast,
   input  wire  [1:0]  req_tuser,   // [0] first_byte, [1] no_payload
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [4:0]  csr_paddr,
   input  wire  [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import wdfb_pkg::*;

   addr_cfg_type addr_ff, addr_in;
   logic         cfg_write;
   logic [1:0]   reg_idx;
   logic         q_full, q_not_empty, push, pop;
   cmd_type      push_cmd, head;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[4:3];
   assign cfg_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      addr_in = addr_ff;
      csr_prdata = '0;
      case (reg_idx)
         REG_DEST: begin
            csr_prdata = {16'd0, addr_ff.dest};
            if (cfg_write) begin
               addr_in.dest = csr_pwdata[47:0];
            end
         end
         REG_SOURCE: begin
            csr_prdata = {16'd0, addr_ff.source};
            if (cfg_write) begin
               addr_in.source = csr_pwdata[47:0];
            end
         end
         REG_BSS: begin
            csr_prdata = {16'd0, addr_ff.bss};
            if (cfg_write) begin
               addr_in.bss = csr_pwdata[47:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else begin
         addr_ff <= addr_in;
      end
   end

   wdfb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_data  (req_tdata),
      .in_first (req_tuser[0]),
      .in_last  (req_tlast),
      .in_empty (req_tuser[1]),
      .q_full   (q_full),
      .in_ready (req_tready),
      .push     (push),
      .push_cmd (push_cmd)
   );

   wdfb_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   wdfb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .addr_cfg    (addr_ff),
      .q_not_empty (q_not_empty),
      .q_head      (head),
      .q_pop       (pop),
      .out_valid   (rsp_tvalid),
      .out_byte    (rsp_tdata),
      .out_end     (rsp_tlast),
      .out_ready   (rsp_tready)
   );

endmodule
`default_nettype wire

### test/tb_wlan_data_frame_builder_unit.sv
`timescale 1ns / 1ps
// Testbench for wlan_data_frame_builder_unit: drives payload beats and address writes and checks
// every frame beat against its own model of the header, sequence counter and CRC-32 FCS.
// Depends on wdfb_pkg and the block's RTL only.
module tb_wlan_data_frame_builder_unit;
   import wdfb_pkg::*;

   localparam logic [31:0] FcsPoly = 32'hEDB88320;
   localparam logic [1:0] REG_NONE = 2'd3;
   localparam int IdleLimit = 1000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
   } frame_beat_type;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
      logic       no_payload;
      logic [5:0] count;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   wire req_tready;
   logic [7:0] req_tdata = 8'd0;   // [7:0] data_byte
   logic req_tlast = 1'b0;
   logic [1:0] req_tuser = 2'd0;   // [0] first_byte, [1] no_payload
   wire rsp_tvalid;
   logic rsp_tready = 1'b0;
   wire [7:0] rsp_tdata;           // [7:0] out_byte
   wire rsp_tlast;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = 5'd0;
   logic [63:0] csr_pwdata = 64'd0;
   wire [63:0] csr_prdata;
   wire csr_pready;

   logic [47:0] mac_addr [3] = '{default: '0};
   logic [11:0] seq_count = 12'd0;
   logic [31:0] crc_acc = '1;
   logic in_frame = 1'b0;
   frame_beat_type frame_q [$];
   logic [5:0] typed_count = 6'd0;
   int fail_count = 0;
   int idle_cycles = 0;
   bit steady = 1'b0;
   int stall_left = 0;
   int run_left = 0;

   dir_row_type dir_rows [14] = '{
      '{8'hFF, 1'b1, 1'b1, 1'b1, 6'd28},
      '{8'h00, 1'b0, 1'b0, 1'b1, 6'd28},
      '{8'h00, 1'b1, 1'b0, 1'b0, 6'd25},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 6'd1},
      '{8'h80, 1'b0, 1'b1, 1'b0, 6'd5},
      '{8'h01, 1'b0, 1'b0, 1'b0, 6'd25},
      '{8'h7F, 1'b1, 1'b0, 1'b0, 6'd25},
      '{8'hA5, 1'b0, 1'b0, 1'b1, 6'd28},
      '{8'h5A, 1'b1, 1'b1, 1'b0, 6'd29},
      '{8'hC3, 1'b0, 1'b1, 1'b0, 6'd29},
      '{8'h3C, 1'b1, 1'b0, 1'b0, 6'd25},
      '{8'h96, 1'b0, 1'b0, 1'b0, 6'd1},
      '{8'h69, 1'b0, 1'b0, 1'b0, 6'd1},
      '{8'hF0, 1'b0, 1'b1, 1'b0, 6'd5}
   };

   wlan_data_frame_builder_unit dut (.*);

   always #1 clock = ~clock;

   function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      repeat (8) r = (r >> 1) ^ (r[0] ? FcsPoly : 32'd0);
      return r;
   endfunction

   task automatic push_beat(input logic [7:0] b, input logic fe, input bit covered);
      if (covered) begin
         crc_acc = crc_update(crc_acc, b);
      end
      frame_q.push_back('{out_byte: b, frame_end: fe});
   endtask

   task automatic push_header();
      logic [15:0] seq_field;
      seq_field = {seq_count, 4'd0};
      crc_acc = '1;
      push_beat(HDR_FC_WORD[7:0], 1'b0, 1'b1);
      push_beat(HDR_FC_WORD[15:8], 1'b0, 1'b1);
      push_beat(DURATION[7:0], 1'b0, 1'b1);
      push_beat(DURATION[15:8], 1'b0, 1'b1);
      for (int a = 0; a < 3; a++) begin
         for (int i = 0; i < 6; i++) begin
            push_beat(mac_addr[a][8*i +: 8], 1'b0, 1'b1);
         end
      end
      push_beat(seq_field[7:0], 1'b0, 1'b1);
      push_beat(seq_field[15:8], 1'b0, 1'b1);
      seq_count = seq_count + 12'd1;
   endtask

   task automatic push_fcs();
      logic [31:0] fcs;
      fcs = ~crc_acc;
      for (int i = 0; i < 4; i++) begin
         push_beat(fcs[8*i +: 8], i == 3, 1'b0);
      end
      crc_acc = '1;
      in_frame = 1'b0;
   endtask

   task automatic frame_model(input logic [7:0] d, input logic first, input logic last,
                              input logic no_payload);
      if (no_payload) begin
         push_header();
         push_fcs();
      end else begin
         if (first || !in_frame) begin
            push_header();
            in_frame = 1'b1;
         end
         push_beat(d, 1'b0, 1'b1);
         if (last) begin
            push_fcs();
         end
      end
   endtask

   // Checks output beats in order and feeds accepted input beats and writes to the model.
   always @(posedge clock) begin
      frame_beat_type want;
      int prior_size;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (frame_q.size() == 0) begin
               $error("unexpected beat: out_byte %h frame_end %b", rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               want = frame_q.pop_front();
               if (rsp_tdata !== want.out_byte) begin
                  $error("out_byte: expected %h, actual %h", want.out_byte, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.frame_end) begin
                  $error("frame_end: expected %b, actual %b", want.frame_end, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            prior_size = frame_q.size();
            frame_model(req_tdata, req_tuser[0], req_tlast, req_tuser[1]);
            if (typed_count != 0 && frame_q.size() - prior_size != typed_count) begin
               $error("beats per input: expected %0d, actual %0d", typed_count,
                      frame_q.size() - prior_size);
               fail_count++;
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[4:3] != REG_NONE)
         begin
            mac_addr[csr_paddr[4:3]] = csr_pwdata[47:0];
         end
      end
   end

   always @(posedge clock) begin
      int pick;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (run_left > 0) begin
         rsp_tready <= 1'b1;
         run_left--;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            rsp_tready <= 1'b1;
         end else if (pick < 75) begin
            rsp_tready <= 1'b1;
            run_left = $urandom_range(30, 200);
         end else if (pick < 97) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(8, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles < IdleLimit) begin
         idle_cycles <= idle_cycles + 1;
      end else begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_beat(input logic [7:0] d, input logic first, input logic last,
                            input logic no_payload, input logic [5:0] count);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= last;
      req_tuser <= {no_payload, first};
      typed_count <= count;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (frame_q.size() != 0);
   endtask

   task automatic csr_access(input logic write, input logic [1:0] idx, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (!write && csr_prdata[47:0] !== mac_addr[idx]) begin
         $error("csr_prdata: expected %h, actual %h", mac_addr[idx], csr_prdata[47:0]);
         fail_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // The write beyond the register list must leave all three addresses unchanged.
   task automatic set_addresses(input logic [63:0] dest, input logic [63:0] source,
                                input logic [63:0] bss);
      wait_drained();
      csr_access(1'b1, REG_DEST, dest);
      csr_access(1'b1, REG_SOURCE, source);
      csr_access(1'b1, REG_BSS, bss);
      csr_access(1'b1, REG_NONE, {$urandom, $urandom});
      csr_access(1'b0, REG_DEST, 64'd0);
      csr_access(1'b0, REG_SOURCE, 64'd0);
      csr_access(1'b0, REG_BSS, 64'd0);
   endtask

   task automatic random_frames(input int n);
      int sent;
      int kind;
      int len;
      bit closed;
      sent = 0;
      while (sent < n) begin
         kind = $urandom_range(0, 99);
         steady = ($urandom_range(0, 7) == 0);
         if (kind < 3) begin
            wait_drained();
         end
         if (kind < 72) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            closed = ($urandom_range(0, 9) != 0);
            for (int i = 0; i < len; i++) begin
               send_beat(8'($urandom_range(0, 255)), i == 0, closed && i == len - 1, 1'b0,
                         6'd0);
            end
            sent += len;
         end else if (kind < 82) begin
            send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b1, 6'd0);
            sent++;
         end else begin
            send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, 6'd0);
            sent++;
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 14; i++) begin
         send_beat(dir_rows[i].data, dir_rows[i].first, dir_rows[i].last,
                   dir_rows[i].no_payload, dir_rows[i].count);
      end
      set_addresses('1, '1, '1);
      random_frames(80);
      set_addresses({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      random_frames(80);
      set_addresses(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h0000_8000_0000_0001);
      random_frames(80);
      set_addresses(64'hFFFF_0000_0000_0000, {$urandom, $urandom}, 64'd0);
      random_frames(80);
      set_addresses({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      random_frames(80);
      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### sim.f
src/wdfb_pkg.sv
src/wdfb_front.sv
src/wdfb_queue.sv
src/wdfb_back.sv
src/wlan_data_frame_builder_unit.sv
test/tb_wlan_data_frame_builder_unit.sv
